>>> hdl/ldpe_pkg.sv
// Shared constants and codes for the linear-to-display pixel encoder.
`timescale 1ns / 1ps
package ldpe_pkg;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int LIN_W            = 20;
    localparam int GAIN_W           = 16;
    localparam int V_W              = 36;   // gain product, Q8.28
    localparam int V_FB             = 28;
    localparam int MANT_W           = 31;   // log mantissa, Q1.30
    localparam int LOG_STEPS        = 24;   // fraction bits of the log
    localparam int LOG_LAT          = LOG_STEPS + 1;
    localparam int P_W              = 6;
    localparam int RHS_W            = 48;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int SA_W             = 8;
    localparam int OUT_W            = 8;

    localparam logic [15:0] GAIN_RESET   = 16'd8192;
    localparam logic [15:0] INVG_RESET   = 16'd1862;
    localparam logic [15:0] INVG_BYPASS  = 16'd4096;

    typedef enum logic [1:0] {
        CFG_GAIN       = 2'd0,
        CFG_INV_GAMMA  = 2'd1,
        CFG_ALPHA_SEL  = 2'd2
    } t_cfg_idx;

    localparam logic [1:0] ALPHA_OPAQUE = 2'd0;
    localparam logic [1:0] ALPHA_LIGHT  = 2'd1;
endpackage

>>> hdl/ldpe_log2.sv
// Pipelined base-2 logarithm: leading-one normalize, then one mantissa squaring per stage.
`timescale 1ns / 1ps
module ldpe_log2 #(
    parameter int XW = 36,
    parameter int SW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [XW-1:0]            i_x,
    input  logic [SW-1:0]            i_side,
    output logic [ldpe_pkg::P_W-1:0] o_p,
    output logic [ldpe_pkg::LOG_STEPS-1:0] o_f,
    output logic [SW-1:0]            o_side
);
    import ldpe_pkg::*;

    logic [MANT_W-1:0]    r_m    [0:LOG_STEPS];
    logic [LOG_STEPS-1:0] r_f    [0:LOG_STEPS];
    logic [P_W-1:0]       r_p    [0:LOG_STEPS];
    logic [SW-1:0]        r_side [0:LOG_STEPS];

    logic [P_W-1:0]    n_p;
    logic [MANT_W-1:0] n_m;
    logic [63:0]       x64;

    // find the leading one and normalize the mantissa to Q1.30
    always_comb begin
        n_p = '0;
        for (int k = 0; k < XW; k++) begin
            if (i_x[k]) n_p = P_W'(k);
        end
        x64 = 64'(i_x);
        if (n_p >= P_W'(30)) begin
            n_m = MANT_W'(x64 >> (n_p - P_W'(30)));
        end else begin
            n_m = MANT_W'(x64 << (P_W'(30) - n_p));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= n_m;
            r_f[0]    <= '0;
            r_p[0]    <= n_p;
            r_side[0] <= i_side;
        end
    end

    // square the mantissa once per stage, one fraction bit from the top down
    for (genvar s = 0; s < LOG_STEPS; s++) begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     t;
        assign sq = r_m[s] * r_m[s];
        assign t  = sq[2*MANT_W-1:MANT_W-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[s+1]    <= r_p[s];
                r_side[s+1] <= r_side[s];
                if (t[MANT_W]) begin
                    r_m[s+1] <= t[MANT_W:1];
                    r_f[s+1] <= r_f[s] | (LOG_STEPS'(1) << (LOG_STEPS-1-s));
                end else begin
                    r_m[s+1] <= t[MANT_W-1:0];
                    r_f[s+1] <= r_f[s];
                end
            end
        end
    end

    assign o_p    = r_p[LOG_STEPS];
    assign o_f    = r_f[LOG_STEPS];
    assign o_side = r_side[LOG_STEPS];
endmodule

>>> hdl/ldpe_lane.sv
// One color lane: gain multiply, log of the product, exponent scale, binary search of the code.
`timescale 1ns / 1ps
module ldpe_lane #(
    parameter int CHANNEL_BITS = ldpe_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ldpe_pkg::LIN_W-1:0]    i_lin,
    input  logic [ldpe_pkg::GAIN_W-1:0]   i_gain,
    input  logic [ldpe_pkg::GAIN_W-1:0]   i_inv_gamma,
    output logic [CHANNEL_BITS-1:0]       o_q
);
    import ldpe_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int SPW = CB + 1;              // special flag and its value
    localparam int STW = RHS_W + CB + SPW;    // sideband through a search step
    localparam logic [CB-1:0] CH_MAX = '1;

    // stage A: product and special cases
    logic [V_W-1:0] n_v;
    logic           n_spec;
    logic [CB-1:0]  n_spec_val;
    logic [V_W-1:0] r_v;
    logic [SPW-1:0] r_spec;

    assign n_v = V_W'(i_lin) * V_W'(i_gain);

    always_comb begin
        n_spec     = 1'b0;
        n_spec_val = '0;
        if (n_v == '0) begin
            n_spec = 1'b1;
        end else if (i_inv_gamma == INVG_BYPASS) begin
            n_spec     = 1'b1;
            n_spec_val = (n_v[V_W-1:V_FB] != '0) ? CH_MAX : n_v[V_FB-1 -: CB];
        end else if (i_inv_gamma == '0 || n_v[V_W-1:V_FB] != '0) begin
            n_spec     = 1'b1;
            n_spec_val = CH_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_spec <= {n_spec, n_spec_val};
        end
    end

    // log of the product
    logic [P_W-1:0]       lv_p;
    logic [LOG_STEPS-1:0] lv_f;
    logic [SPW-1:0]       lv_spec;

    ldpe_log2 #(.XW(V_W), .SW(SPW)) u_log_v (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r_v),
        .i_side (r_spec),
        .o_p    (lv_p),
        .o_f    (lv_f),
        .o_side (lv_spec)
    );

    // stage B: scale the log by the exponent
    logic signed [6:0]           pd_v;
    logic signed [30:0]          lg_v;
    logic signed [RHS_W-1:0]     n_rhs;
    logic signed [RHS_W-1:0]     r_rhs;
    logic [SPW-1:0]              r_spec_b;

    assign pd_v  = $signed({1'b0, lv_p}) - 7'sd28;
    assign lg_v  = {pd_v, lv_f};
    assign n_rhs = RHS_W'($signed({1'b0, i_inv_gamma})) * RHS_W'(lg_v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rhs    <= n_rhs;
            r_spec_b <= lv_spec;
        end
    end

    // search steps, top bit first
    logic [CB-1:0]          q_w    [0:CB];
    logic signed [RHS_W-1:0] rhs_w [0:CB];
    logic [SPW-1:0]         spec_w [0:CB];

    assign q_w[0]    = '0;
    assign rhs_w[0]  = r_rhs;
    assign spec_w[0] = r_spec_b;

    for (genvar j = 0; j < CB; j++) begin : g_step
        localparam int B = CB - 1 - j;
        logic [CB-1:0]        cand;
        logic [STW-1:0]       side_o;
        logic [P_W-1:0]       c_p;
        logic [LOG_STEPS-1:0] c_f;
        logic [CB-1:0]        q_o;
        logic [CB-1:0]        cand_o;
        logic signed [6:0]    pd_c;
        logic signed [30:0]   lg_c;
        logic signed [RHS_W-1:0] lhs;
        logic signed [RHS_W-1:0] rhs_o;

        assign cand = q_w[j] | (CB'(1) << B);

        ldpe_log2 #(.XW(CB), .SW(STW)) u_log_c (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x    (cand),
            .i_side ({rhs_w[j], q_w[j], spec_w[j]}),
            .o_p    (c_p),
            .o_f    (c_f),
            .o_side (side_o)
        );

        assign rhs_o  = side_o[STW-1 -: RHS_W];
        assign q_o    = side_o[SPW +: CB];
        assign cand_o = q_o | (CB'(1) << B);
        assign pd_c   = $signed({1'b0, c_p}) - 7'(CB);
        assign lg_c   = {pd_c, c_f};
        assign lhs    = RHS_W'(lg_c) <<< 12;

        // keep the candidate bit when its scaled log stays at or below the bound
        assign q_w[j+1]    = (lhs <= rhs_o) ? cand_o : q_o;
        assign rhs_w[j+1]  = rhs_o;
        assign spec_w[j+1] = side_o[SPW-1:0];
    end

    // select the special-case value or the search result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= spec_w[CB][CB] ? spec_w[CB][CB-1:0] : q_w[CB];
        end
    end
endmodule

>>> hdl/linear_to_display_pixel_encode_top.sv
// Top level of the linear-to-display pixel encoder: config, three lanes, alpha merge.
`timescale 1ns / 1ps
// Usage:
//   Slave stream i_s_axis_* carries one linear pixel per transfer (three Q4.16
//   channels and the source alpha); master stream o_m_axis_* returns the
//   encoded pixel and its alpha. The cfg channel writes gain, inv_gamma and
//   the alpha select by index; it is always ready and should only be used
//   while no pixel is in flight.
//   Throughput is one pixel per clock while the receiver does not stall. The path
//   from input transfer to output valid runs through one gain multiply, a 25-stage log
//   of the product, an exponent multiply, one 25-stage log per bit of the
//   code search, the lane register and the output register.
//   The three color lanes run side by side; the merge stage forms the alpha.
//   Reset (synchronous, active low) empties the pipeline and restores the
//   register defaults: gain 2.0, inv_gamma 1862, opaque alpha.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_s_axis_tready drops until the waiting result is taken.
module linear_to_display_pixel_encode_top #(
    parameter int CHANNEL_BITS = ldpe_pkg::CHANNEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ldpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ldpe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // lin_red[19:0], lin_green[39:20], lin_blue[59:40], source_alpha[67:60], zero pad
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0] o_m_axis_tdata
);
    import ldpe_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int LAT = 1 + LOG_LAT + 1 + CB * LOG_LAT + 1;
    localparam logic [CB-1:0] CH_MAX = '1;

    // configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [GAIN_W-1:0] r_inv_gamma;
    logic [1:0]        r_alpha_sel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RESET;
            r_inv_gamma  <= INVG_RESET;
            r_alpha_sel  <= ALPHA_OPAQUE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN:       r_gain       <= i_cfg_data;
                CFG_INV_GAMMA:  r_inv_gamma  <= i_cfg_data;
                CFG_ALPHA_SEL:  r_alpha_sel  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // advance the pipeline unless a result waits on a stalled receiver
    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;

    logic [CB-1:0] q_r, q_g, q_b;

    ldpe_lane #(.CHANNEL_BITS(CB)) u_lane_r (
        .i_clk(i_clk), .i_en(en), .i_lin(i_s_axis_tdata[19:0]),
        .i_gain(r_gain), .i_inv_gamma(r_inv_gamma), .o_q(q_r));
    ldpe_lane #(.CHANNEL_BITS(CB)) u_lane_g (
        .i_clk(i_clk), .i_en(en), .i_lin(i_s_axis_tdata[39:20]),
        .i_gain(r_gain), .i_inv_gamma(r_inv_gamma), .o_q(q_g));
    ldpe_lane #(.CHANNEL_BITS(CB)) u_lane_b (
        .i_clk(i_clk), .i_en(en), .i_lin(i_s_axis_tdata[59:40]),
        .i_gain(r_gain), .i_inv_gamma(r_inv_gamma), .o_q(q_b));

    // carry valid and source alpha alongside the lanes
    logic [LAT-1:0]  r_vld;
    logic [SA_W-1:0] r_sa [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= i_s_axis_tdata[67:60];
            for (int k = 1; k < LAT; k++) r_sa[k] <= r_sa[k-1];
        end
    end

    // merge lanes into the output alpha
    logic [CB-1:0] m_rg, m_rgb, n_alpha;
    logic [CB-1:0] sa_ext;

    assign sa_ext = CB'(r_sa[LAT-1]);
    assign m_rg   = (q_g > q_r) ? q_g : q_r;
    assign m_rgb  = (q_b > m_rg) ? q_b : m_rg;

    always_comb begin
        case (r_alpha_sel)
            ALPHA_OPAQUE: n_alpha = CH_MAX;
            ALPHA_LIGHT:  n_alpha = m_rgb;
            default:      n_alpha = (sa_ext > m_rgb) ? sa_ext : m_rgb;
        endcase
    end

    logic [31:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= {n_alpha[OUT_W-1:0], q_b[OUT_W-1:0], q_g[OUT_W-1:0], q_r[OUT_W-1:0]};
        end
    end

    assign o_m_axis_tdata = r_out;

    // a waiting result holds through a stall
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("result lost during stall");

    // a pixel leaving the lanes reaches the output register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[LAT-1]) |=> r_out_valid)
        else $error("pixel dropped at merge");

    // the in-flight marks freeze while stalled
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
endmodule
